// File: sv/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Types and codes shared by the step sequencer controller and datapath.
// ----------------------------------------------------------------------------
package tss_pkg;

  typedef enum logic [3:0] {
    OP_TICK = 4'd0, OP_APPEND = 4'd1, OP_JOIN = 4'd2, OP_INSERT = 4'd3,
    OP_REMOVE = 4'd4, OP_MOVE = 4'd5, OP_UPDATE = 4'd6, OP_SEEK = 4'd7,
    OP_SETTIMER = 4'd8, OP_PLAY = 4'd9, OP_STOP = 4'd10, OP_CLEAR = 4'd11
  } op_t;

  localparam logic [1:0] KIND_ANIM = 2'd0;
  localparam logic [1:0] KIND_VIS  = 2'd1;
  localparam logic [1:0] KIND_CB   = 2'd2;
  localparam logic [1:0] KIND_WAIT = 2'd3;

  localparam logic [1:0] RES_STATUS = 2'd0;
  localparam logic [1:0] RES_ANIM   = 2'd1;
  localparam logic [1:0] RES_VIS    = 2'd2;
  localparam logic [1:0] RES_CB     = 2'd3;

  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  index;
    logic [3:0]  index_to;
    logic [1:0]  step_kind;
    logic [7:0]  target_id;
    logic [7:0]  anim_id;
    logic        visible_flag;
    logic [7:0]  callback_id;
    logic [31:0] wait_time;
    logic        join_flag;
    logic [31:0] time_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_target;
    logic [7:0] out_anim;
    logic       out_visible;
    logic [7:0] out_callback;
    logic       accepted;
    logic       playing_now;
    logic [4:0] cursor_now;
    logic [4:0] count_now;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  target;
    logic [7:0]  anim;
    logic        vis;
    logic [7:0]  cb;
    logic [31:0] wait_time;
    logic        join_flag;
  } entry_t;

  // Datapath commands issued by the controller. DP_COPY writes the word
  // fetched by the previous read back to the given address.
  typedef enum logic [3:0] {
    DP_NONE, DP_READ, DP_COPY, DP_WRITE_IN, DP_WRITE_HOLD, DP_LOAD_HOLD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [5:0] addr;
  } dp_cmd_t;

endpackage

// File: sv/tss_table.sv
// ----------------------------------------------------------------------------
// tss_table
// Step table memory with one registered read port, through which entries are
// shifted during insert, remove and move, and a hold register for a moved entry.
// ----------------------------------------------------------------------------
module tss_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk,
  input  tss_pkg::dp_cmd_t  cmd,
  input  tss_pkg::entry_t   wr_entry,
  output tss_pkg::entry_t   rd_entry
);

  localparam int unsigned AW = $clog2(DEPTH);

  tss_pkg::entry_t mem [DEPTH];
  tss_pkg::entry_t rd_r;
  tss_pkg::entry_t hold_r;
  logic [AW-1:0]   a;

  assign a = cmd.addr[AW-1:0];

  // A shift is a read of the neighbor followed by a copy of that word.
  always_ff @(posedge clk) begin
    case (cmd.op)
      tss_pkg::DP_READ:       rd_r <= mem[a];
      tss_pkg::DP_COPY:       mem[a] <= rd_r;
      tss_pkg::DP_WRITE_IN:   mem[a] <= wr_entry;
      tss_pkg::DP_WRITE_HOLD: mem[a] <= hold_r;
      tss_pkg::DP_LOAD_HOLD:  hold_r <= rd_r;
      default: ;
    endcase
  end

  assign rd_entry = rd_r;

endmodule

// File: sv/tss_ctrl.sv
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer controller: decodes each word, walks the table for ticks and
// table edits, and drives the result strobe.
// ----------------------------------------------------------------------------
module tss_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tss_pkg::in_word_t   in_word,
  input  tss_pkg::entry_t     rd_entry,
  output logic                busy,
  output tss_pkg::dp_cmd_t    cmd,
  output tss_pkg::entry_t     wr_entry,
  output logic                out_valid,
  output tss_pkg::out_word_t  out_word
);

  localparam int unsigned   CW   = $clog2(DEPTH + 1);
  localparam int unsigned   XW   = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] DepC = CW'(DEPTH);
  localparam logic [31:0]   TMax = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SH_RD, S_SH_WR, S_SH_END, S_MV_RD, S_MV_HOLD,
    S_TK_RD, S_TK_STEP, S_STATUS
  } state_t;

  state_t              state_r, state_nxt;
  tss_pkg::in_word_t   iw_r, iw_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       cursor_r, cursor_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic [CW-1:0]       stop_r, stop_nxt;
  logic [31:0]         timer_r, timer_nxt;
  logic                playing_r, playing_nxt;
  logic                started_r, started_nxt;
  logic                acc_r, acc_nxt;
  logic                up_r, up_nxt;
  logic                chk_r, chk_nxt;
  logic                out_valid_r, out_valid_nxt;
  tss_pkg::out_word_t  out_r, out_nxt;
  logic [XW-1:0]       idx_x, to_x, cnt_x;
  logic [CW-1:0]       idx_c, to_c, cur_inc_c, ptr_step_c;
  logic [32:0]         tsum_c;
  logic [31:0]         tsat_c;
  logic                adv_c;

  assign idx_x      = XW'(iw_r.index);
  assign to_x       = XW'(iw_r.index_to);
  assign cnt_x      = XW'(count_r);
  assign idx_c      = CW'(iw_r.index);
  assign to_c       = CW'(iw_r.index_to);
  assign cur_inc_c  = cursor_r + CW'(1);
  assign ptr_step_c = up_r ? ptr_r - CW'(1) : ptr_r + CW'(1);
  assign tsum_c = {1'b0, (started_r ? timer_r : 32'd0)} + {1'b0, iw_r.time_value};
  assign tsat_c = tsum_c[32] ? TMax : tsum_c[31:0];

  always_comb begin
    wr_entry.kind      = iw_r.step_kind;
    wr_entry.target    = iw_r.target_id;
    wr_entry.anim      = iw_r.anim_id;
    wr_entry.vis       = iw_r.visible_flag;
    wr_entry.cb        = iw_r.callback_id;
    wr_entry.wait_time = iw_r.wait_time;
    wr_entry.join_flag = (iw_r.op == tss_pkg::OP_APPEND) ? 1'b0 :
                         (iw_r.op == tss_pkg::OP_JOIN) ? 1'b1 : iw_r.join_flag;
  end

  always_comb begin
    cmd.op   = tss_pkg::DP_NONE;
    cmd.addr = '0;
    case (state_r)
      S_SH_RD: begin
        cmd.op   = tss_pkg::DP_READ;
        cmd.addr = 6'(ptr_step_c);
      end
      S_SH_WR: begin
        cmd.op   = tss_pkg::DP_COPY;
        cmd.addr = 6'(ptr_r);
      end
      S_SH_END: begin
        if (iw_r.op == tss_pkg::OP_MOVE) cmd.op = tss_pkg::DP_WRITE_HOLD;
        else cmd.op = tss_pkg::DP_WRITE_IN;
        cmd.addr = 6'(stop_r);
      end
      S_MV_RD: begin
        cmd.op   = tss_pkg::DP_READ;
        cmd.addr = 6'(idx_c);
      end
      S_MV_HOLD: cmd.op = tss_pkg::DP_LOAD_HOLD;
      S_TK_RD: begin
        cmd.op   = tss_pkg::DP_READ;
        cmd.addr = 6'(cursor_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    iw_nxt        = iw_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    ptr_nxt       = ptr_r;
    stop_nxt      = stop_r;
    timer_nxt     = timer_r;
    playing_nxt   = playing_r;
    started_nxt   = started_r;
    acc_nxt       = acc_r;
    up_nxt        = up_r;
    chk_nxt       = chk_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    adv_c         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          iw_nxt    = in_word;
          acc_nxt   = 1'b0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_STATUS;
        case (iw_r.op)
          tss_pkg::OP_TICK: begin
            acc_nxt = 1'b1;
            chk_nxt = 1'b0;
            if (playing_r) begin
              if (cursor_r >= count_r) playing_nxt = 1'b0;
              else state_nxt = S_TK_RD;
            end
          end
          tss_pkg::OP_APPEND, tss_pkg::OP_JOIN: begin
            if (!playing_r && count_r < DepC) begin
              acc_nxt   = 1'b1;
              stop_nxt  = count_r;
              count_nxt = count_r + CW'(1);
              state_nxt = S_SH_END;
            end
          end
          tss_pkg::OP_INSERT: begin
            if (!playing_r && count_r < DepC && idx_x <= cnt_x) begin
              acc_nxt   = 1'b1;
              count_nxt = count_r + CW'(1);
              up_nxt    = 1'b1;
              ptr_nxt   = count_r;
              stop_nxt  = idx_c;
              if (idx_c == count_r) state_nxt = S_SH_END;
              else state_nxt = S_SH_RD;
            end
          end
          tss_pkg::OP_REMOVE: begin
            if (!playing_r && idx_x < cnt_x) begin
              acc_nxt   = 1'b1;
              count_nxt = count_r - CW'(1);
              up_nxt    = 1'b0;
              ptr_nxt   = idx_c;
              stop_nxt  = count_r - CW'(1);
              if (idx_c != count_r - CW'(1)) state_nxt = S_SH_RD;
            end
          end
          tss_pkg::OP_MOVE: begin
            if (!playing_r && idx_x < cnt_x && to_x < cnt_x) begin
              acc_nxt  = 1'b1;
              up_nxt   = idx_c > to_c;
              ptr_nxt  = idx_c;
              stop_nxt = to_c;
              if (idx_c != to_c) state_nxt = S_MV_RD;
            end
          end
          tss_pkg::OP_UPDATE: begin
            if (!playing_r && idx_x < cnt_x) begin
              acc_nxt   = 1'b1;
              stop_nxt  = idx_c;
              state_nxt = S_SH_END;
            end
          end
          tss_pkg::OP_SEEK: begin
            if (idx_x < cnt_x) begin
              cursor_nxt  = idx_c;
              timer_nxt   = '0;
              started_nxt = 1'b0;
              acc_nxt     = 1'b1;
            end
          end
          tss_pkg::OP_SETTIMER: begin
            timer_nxt = iw_r.time_value;
            acc_nxt   = 1'b1;
          end
          tss_pkg::OP_PLAY: begin
            if (count_r != '0) begin
              cursor_nxt  = '0;
              timer_nxt   = '0;
              started_nxt = 1'b0;
              playing_nxt = 1'b1;
              acc_nxt     = 1'b1;
            end
          end
          tss_pkg::OP_STOP: begin
            playing_nxt = 1'b0;
            cursor_nxt  = DepC;
            timer_nxt   = '0;
            started_nxt = 1'b0;
            acc_nxt     = 1'b1;
          end
          tss_pkg::OP_CLEAR: begin
            if (!playing_r) begin
              count_nxt = '0;
              acc_nxt   = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: begin
        // The neighbor read in the previous cycle lands at ptr now.
        ptr_nxt = ptr_step_c;
        if (ptr_step_c == stop_r) begin
          if (iw_r.op == tss_pkg::OP_REMOVE) state_nxt = S_STATUS;
          else state_nxt = S_SH_END;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_SH_END: state_nxt = S_STATUS;
      S_MV_RD: state_nxt = S_MV_HOLD;
      S_MV_HOLD: state_nxt = S_SH_RD;
      S_TK_RD: state_nxt = S_TK_STEP;
      S_TK_STEP: begin
        state_nxt = S_STATUS;
        // After a finished wait, the chain goes on only into a joined step.
        if (!(chk_r && !rd_entry.join_flag)) begin
          if (!started_r) begin
            if (rd_entry.kind == tss_pkg::KIND_ANIM && rd_entry.target != 8'd0) begin
              out_valid_nxt          = 1'b1;
              out_nxt                = '0;
              out_nxt.result_kind    = tss_pkg::RES_ANIM;
              out_nxt.out_target     = rd_entry.target;
              out_nxt.out_anim       = rd_entry.anim;
            end else if (rd_entry.kind == tss_pkg::KIND_VIS &&
                         rd_entry.target != 8'd0) begin
              out_valid_nxt          = 1'b1;
              out_nxt                = '0;
              out_nxt.result_kind    = tss_pkg::RES_VIS;
              out_nxt.out_target     = rd_entry.target;
              out_nxt.out_visible    = rd_entry.vis;
            end else if (rd_entry.kind == tss_pkg::KIND_CB && rd_entry.cb != 8'd0) begin
              out_valid_nxt          = 1'b1;
              out_nxt                = '0;
              out_nxt.result_kind    = tss_pkg::RES_CB;
              out_nxt.out_callback   = rd_entry.cb;
            end
          end
          if (rd_entry.kind == tss_pkg::KIND_WAIT) begin
            timer_nxt = tsat_c;
            if (tsat_c >= rd_entry.wait_time) adv_c = 1'b1;
            else started_nxt = 1'b1;
          end else begin
            adv_c = 1'b1;
          end
          if (adv_c) begin
            cursor_nxt  = cur_inc_c;
            started_nxt = 1'b0;
            chk_nxt     = (rd_entry.kind == tss_pkg::KIND_WAIT);
            if (cur_inc_c >= count_r) playing_nxt = 1'b0;
            else state_nxt = S_TK_RD;
          end
        end
      end
      S_STATUS: begin
        out_valid_nxt       = 1'b1;
        out_nxt             = '0;
        out_nxt.result_kind = tss_pkg::RES_STATUS;
        out_nxt.accepted    = acc_r;
        out_nxt.playing_now = playing_r;
        out_nxt.cursor_now  = 5'(cursor_r);
        out_nxt.count_now   = 5'(count_r);
        out_nxt.last        = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iw_r        <= '0;
      count_r     <= '0;
      cursor_r    <= DepC;
      ptr_r       <= '0;
      stop_r      <= '0;
      timer_r     <= '0;
      playing_r   <= 1'b0;
      started_r   <= 1'b0;
      acc_r       <= 1'b0;
      up_r        <= 1'b0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      iw_r        <= iw_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      ptr_r       <= ptr_nxt;
      stop_r      <= stop_nxt;
      timer_r     <= timer_nxt;
      playing_r   <= playing_nxt;
      started_r   <= started_nxt;
      acc_r       <= acc_nxt;
      up_r        <= up_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

// File: sv/timed_step_sequencer.sv
// ----------------------------------------------------------------------------
// timed_step_sequencer
// Table of timed steps with edit, seek and playback operations.
// ----------------------------------------------------------------------------
// Throughput: one word at a time; busy drops in the cycle the status word is
// out. Reset: synchronous; count, timer and play flags clear, the cursor is set
// to DEPTH, and table contents stay undefined. The receiver cannot stall.
// ----------------------------------------------------------------------------
module timed_step_sequencer #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tss_pkg::in_word_t   in_word,
  output logic                out_valid,
  output tss_pkg::out_word_t  out_word
);

  tss_pkg::dp_cmd_t cmd;
  tss_pkg::entry_t  wr_entry, rd_entry;

  tss_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk, .rst_n, .start, .in_word, .rd_entry, .busy, .cmd,
    .wr_entry, .out_valid, .out_word
  );

  tss_table #(.DEPTH(DEPTH)) u_table (
    .clk, .cmd, .wr_entry, .rd_entry
  );

endmodule

// File: dv/tb_timed_step_sequencer.sv
// ----------------------------------------------------------------------------
// tb_timed_step_sequencer
// Drives edit, seek and playback words into the step sequencer and checks
// every action and status word against a behavioral predictor of the table.
// ----------------------------------------------------------------------------
module tb_timed_step_sequencer;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned EXP_DEPTH = 64;
  localparam int unsigned MAX_ROWS = 32;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  tss_pkg::in_word_t in_word;
  logic out_valid;
  tss_pkg::out_word_t out_word;

  timed_step_sequencer #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state.
  tss_pkg::entry_t seq_table [DEPTH];
  int unsigned seq_count;
  int unsigned seq_cursor;
  logic [31:0] seq_timer;
  bit          seq_playing;
  bit          seq_started;

  // Expected words in order, as a ring with separate write and read counts.
  tss_pkg::out_word_t exp_mem [EXP_DEPTH];
  int unsigned        exp_wr;
  int unsigned        exp_rd;
  tss_pkg::out_word_t last_status;
  int                 mismatch_count;
  int                 idle_pct;

  function automatic void queue_expected(tss_pkg::out_word_t w);
    exp_mem[exp_wr % EXP_DEPTH] = w;
    exp_wr++;
  endfunction

  function automatic tss_pkg::out_word_t action_word(logic [1:0] kind, logic [7:0] tgt,
                                                     logic [7:0] anim, logic vis,
                                                     logic [7:0] cb);
    tss_pkg::out_word_t w;
    w = '0;
    w.result_kind = kind;
    w.out_target = tgt;
    w.out_anim = anim;
    w.out_visible = vis;
    w.out_callback = cb;
    return w;
  endfunction

  task automatic play_tick(logic [31:0] delta);
    tss_pkg::entry_t s;
    logic [1:0] prev;
    bit done;
    if (!seq_playing) return;
    if (seq_cursor >= seq_count) begin
      seq_playing = 0;
      return;
    end
    forever begin
      s = seq_table[seq_cursor];
      if (!seq_started) begin
        if (s.kind == tss_pkg::KIND_ANIM && s.target != 0)
          queue_expected(action_word(tss_pkg::RES_ANIM, s.target, s.anim, 0, 0));
        else if (s.kind == tss_pkg::KIND_VIS && s.target != 0)
          queue_expected(action_word(tss_pkg::RES_VIS, s.target, 0, s.vis, 0));
        else if (s.kind == tss_pkg::KIND_CB && s.cb != 0)
          queue_expected(action_word(tss_pkg::RES_CB, 0, 0, 0, s.cb));
        else if (s.kind == tss_pkg::KIND_WAIT)
          seq_timer = 0;
        seq_started = 1;
      end
      if (s.kind == tss_pkg::KIND_WAIT) begin
        seq_timer = (delta > TIME_MAX - seq_timer) ? TIME_MAX : seq_timer + delta;
        done = seq_timer >= s.wait_time;
      end else begin
        done = 1;
      end
      if (!done) return;
      prev = s.kind;
      seq_cursor++;
      seq_started = 0;
      if (seq_cursor >= seq_count) begin
        seq_playing = 0;
        return;
      end
      if (!(seq_table[seq_cursor].join_flag || prev != tss_pkg::KIND_WAIT)) return;
    end
  endtask

  // Applies one word to the predicted table and queues the words it causes.
  task automatic predict_word(tss_pkg::in_word_t w);
    tss_pkg::entry_t e, m;
    bit acc;
    int unsigned idx, dst;
    tss_pkg::out_word_t st;
    acc = 0;
    idx = w.index;
    dst = w.index_to;
    e.kind = w.step_kind;
    e.target = w.target_id;
    e.anim = w.anim_id;
    e.vis = w.visible_flag;
    e.cb = w.callback_id;
    e.wait_time = w.wait_time;
    e.join_flag = w.join_flag;
    case (w.op)
      tss_pkg::OP_TICK: begin
        play_tick(w.time_value);
        acc = 1;
      end
      tss_pkg::OP_APPEND, tss_pkg::OP_JOIN: if (!seq_playing && seq_count < DEPTH) begin
        e.join_flag = (w.op == tss_pkg::OP_JOIN);
        seq_table[seq_count++] = e;
        acc = 1;
      end
      tss_pkg::OP_INSERT:
        if (!seq_playing && seq_count < DEPTH && idx <= seq_count) begin
          for (int i = seq_count; i > idx; i--) seq_table[i] = seq_table[i-1];
          seq_table[idx] = e;
          seq_count++;
          acc = 1;
        end
      tss_pkg::OP_REMOVE: if (!seq_playing && idx < seq_count) begin
        for (int i = idx; i + 1 < seq_count; i++) seq_table[i] = seq_table[i+1];
        seq_count--;
        acc = 1;
      end
      tss_pkg::OP_MOVE: if (!seq_playing && idx < seq_count && dst < seq_count) begin
        m = seq_table[idx];
        if (idx < dst)
          for (int i = idx; i < dst; i++) seq_table[i] = seq_table[i+1];
        else
          for (int i = idx; i > dst; i--) seq_table[i] = seq_table[i-1];
        seq_table[dst] = m;
        acc = 1;
      end
      tss_pkg::OP_UPDATE: if (!seq_playing && idx < seq_count) begin
        seq_table[idx] = e;
        acc = 1;
      end
      tss_pkg::OP_SEEK: if (idx < seq_count) begin
        seq_cursor = idx;
        seq_timer = 0;
        seq_started = 0;
        acc = 1;
      end
      tss_pkg::OP_SETTIMER: begin
        seq_timer = w.time_value;
        acc = 1;
      end
      tss_pkg::OP_PLAY: if (seq_count != 0) begin
        seq_cursor = 0;
        seq_timer = 0;
        seq_started = 0;
        seq_playing = 1;
        acc = 1;
      end
      tss_pkg::OP_STOP: begin
        seq_playing = 0;
        seq_cursor = DEPTH;
        seq_timer = 0;
        seq_started = 0;
        acc = 1;
      end
      tss_pkg::OP_CLEAR: if (!seq_playing) begin
        seq_count = 0;
        acc = 1;
      end
      default: ;
    endcase
    st = '0;
    st.result_kind = tss_pkg::RES_STATUS;
    st.accepted = acc;
    st.playing_now = seq_playing;
    st.cursor_now = seq_cursor[4:0];
    st.count_now = seq_count[4:0];
    st.last = 1'b1;
    queue_expected(st);
    last_status = st;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (exp_rd == exp_wr) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected word %h", out_word);
      end else begin
        if (out_word !== exp_mem[exp_rd % EXP_DEPTH]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: expected %p, got %p", exp_mem[exp_rd % EXP_DEPTH], out_word);
        end
        exp_rd++;
      end
    end
  end

  function automatic tss_pkg::in_word_t make_word(tss_pkg::op_t op, int unsigned idx,
                                                  int unsigned dst, logic [1:0] kind,
                                                  logic [7:0] tgt, logic [31:0] wt,
                                                  logic [31:0] tv);
    tss_pkg::in_word_t w;
    w.op = op;
    w.index = 5'(idx);
    w.index_to = 4'(dst);
    w.step_kind = kind;
    w.target_id = tgt;
    w.anim_id = 8'($urandom);
    w.visible_flag = 1'($urandom);
    w.callback_id = (kind == tss_pkg::KIND_CB) ? tgt : 8'($urandom);
    w.wait_time = wt;
    w.join_flag = 1'($urandom);
    w.time_value = tv;
    return w;
  endfunction

  // Sends one word, with a random gap ahead of it in the idle phases.
  task automatic send_word(tss_pkg::in_word_t w);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    while (busy) @(negedge clk);
    in_word <= w;
    start <= 1'b1;
    @(posedge clk);
    predict_word(w);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // A random word: mostly table building and playback, with some noise.
  function automatic tss_pkg::in_word_t random_word();
    int unsigned r;
    tss_pkg::in_word_t w;
    r = $urandom_range(99);
    w = make_word(tss_pkg::OP_TICK, $urandom_range(0, seq_count), $urandom_range(0, 15),
                  2'($urandom), $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom),
                  $urandom_range(0, 3) == 0 ? 32'($urandom) : $urandom_range(0, 32'h3_0000),
                  $urandom_range(0, 7) == 0 ? 32'($urandom) : $urandom_range(0, 32'h2_0000));
    w.wait_time = (w.wait_time == 0 && $urandom_range(1)) ? TIME_MAX : w.wait_time;
    if (r < 35) w.op = tss_pkg::OP_TICK;
    else if (r < 45) w.op = tss_pkg::OP_APPEND;
    else if (r < 52) w.op = tss_pkg::OP_JOIN;
    else if (r < 57) w.op = tss_pkg::OP_INSERT;
    else if (r < 61) w.op = tss_pkg::OP_REMOVE;
    else if (r < 65) w.op = tss_pkg::OP_MOVE;
    else if (r < 69) w.op = tss_pkg::OP_UPDATE;
    else if (r < 73) w.op = tss_pkg::OP_SEEK;
    else if (r < 77) w.op = tss_pkg::OP_SETTIMER;
    else if (r < 86) w.op = tss_pkg::OP_PLAY;
    else if (r < 91) w.op = tss_pkg::OP_STOP;
    else if (r < 94) w.op = tss_pkg::OP_CLEAR;
    else if (r < 97) w.op = tss_pkg::op_t'($urandom_range(12, 15));
    else w.index = 5'($urandom_range(0, 31));
    return w;
  endfunction

  typedef struct {
    tss_pkg::in_word_t  w;
    bit                 has_exp;
    tss_pkg::out_word_t exp_status;
  } table_row_t;

  function automatic tss_pkg::out_word_t status_of(bit acc, bit play, int unsigned cur,
                                                   int unsigned cnt);
    tss_pkg::out_word_t s;
    s = '0;
    s.accepted = acc;
    s.playing_now = play;
    s.cursor_now = 5'(cur);
    s.count_now = 5'(cnt);
    s.last = 1'b1;
    return s;
  endfunction

  table_row_t rows [MAX_ROWS];
  int         row_count;
  int         phase_pct[4] = '{0, 81, 0, 35};

  function automatic void add_row(tss_pkg::in_word_t w, bit has_exp,
                                  tss_pkg::out_word_t exp_status);
    rows[row_count] = '{w, has_exp, exp_status};
    row_count++;
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    mismatch_count = 0;
    idle_pct = 0;
    exp_wr = 0;
    exp_rd = 0;
    last_status = '0;
    row_count = 0;
    seq_count = 0;
    seq_cursor = DEPTH;
    seq_timer = 0;
    seq_playing = 0;
    seq_started = 0;
    for (int i = 0; i < DEPTH; i++) seq_table[i] = '0;
    // Directed rows: rejections, extremes and each step kind.
    add_row(make_word(tss_pkg::OP_TICK, 0, 0, 0, 0, 0, 0), 1, status_of(1, 0, 16, 0));
    add_row(make_word(tss_pkg::OP_PLAY, 0, 0, 0, 0, 0, 0), 1, status_of(0, 0, 16, 0));
    add_row(make_word(tss_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0), 1, status_of(0, 0, 16, 0));
    add_row(make_word(tss_pkg::OP_SEEK, 16, 0, 0, 0, 0, 0), 1, status_of(0, 0, 16, 0));
    add_row(make_word(tss_pkg::op_t'(4'd15), 0, 0, 0, 0, 0, 0), 1,
            status_of(0, 0, 16, 0));
    add_row(make_word(tss_pkg::OP_APPEND, 0, 0, tss_pkg::KIND_ANIM, 8'hFF, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_APPEND, 0, 0, tss_pkg::KIND_VIS, 8'd0, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_JOIN, 0, 0, tss_pkg::KIND_CB, 8'd1, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_APPEND, 0, 0, tss_pkg::KIND_WAIT, 0, 32'h2_0000, 0),
            0, '0);
    add_row(make_word(tss_pkg::OP_JOIN, 0, 0, tss_pkg::KIND_VIS, 8'h80, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_INSERT, 5, 0, tss_pkg::KIND_CB, 8'd0, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_INSERT, 7, 0, tss_pkg::KIND_CB, 8'd9, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_MOVE, 0, 4, 0, 0, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_MOVE, 2, 2, 0, 0, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_UPDATE, 1, 0, tss_pkg::KIND_WAIT, 0, TIME_MAX, 0),
            0, '0);
    add_row(make_word(tss_pkg::OP_PLAY, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_APPEND, 0, 0, 0, 8'd3, 0, 0), 1, status_of(0, 1, 0, 6));
    add_row(make_word(tss_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'h1_0000), 0, '0);
    add_row(make_word(tss_pkg::OP_SETTIMER, 0, 0, 0, 0, 0, 32'hFFFF_FF00), 0, '0);
    add_row(make_word(tss_pkg::OP_TICK, 0, 0, 0, 0, 0, TIME_MAX), 0, '0);
    add_row(make_word(tss_pkg::OP_SEEK, 3, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_TICK, 0, 0, 0, 0, 0, 32'h3_0000), 0, '0);
    add_row(make_word(tss_pkg::OP_TICK, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(make_word(tss_pkg::OP_STOP, 0, 0, 0, 0, 0, 0), 1, status_of(1, 0, 16, 6));
    add_row(make_word(tss_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0), 1, status_of(1, 0, 16, 0));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int i = 0; i < row_count; i++) begin
      send_word(rows[i].w);
      if (rows[i].has_exp && last_status !== rows[i].exp_status) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: row %0d status expected %p, predicted %p", i,
                   rows[i].exp_status, last_status);
      end
    end
    // Fill the table to full once so the full rejections are reached.
    for (int i = 0; i < DEPTH + 2; i++)
      send_word(make_word(i[0] ? tss_pkg::OP_JOIN : tss_pkg::OP_APPEND, 0, 0,
                          2'($urandom), 8'($urandom), $urandom_range(0, 32'h1_0000), 0));
    send_word(make_word(tss_pkg::OP_INSERT, 0, 0, 0, 1, 0, 0));
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      for (int i = 0; i < 25; i++) send_word(random_word());
    end
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
